>>> rtl/nrmc_pkg.sv
// Shared types, character codes and lookup functions for the RMC position parser.
`timescale 1ns / 1ps
package nrmc_pkg;

   localparam int BYTE_W = 8;
   localparam int ACC_W  = 34;
   localparam int OUT_W  = 35;
   localparam int POW_W  = 24;

   typedef logic [ACC_W-1:0]        mag_type;
   typedef logic signed [OUT_W-1:0] coord_type;
   typedef logic [BYTE_W-1:0]       char_type;

   typedef enum logic [2:0] {
      PH_INT  = 3'b001,
      PH_FRAC = 3'b010,
      PH_STOP = 3'b100
   } phase_type;

   typedef struct packed {
      mag_type   acc;
      logic [2:0] seen;
      phase_type phase;
   } num_type;

   localparam num_type NUM_CLEAR = '{acc: '0, seen: 3'd0, phase: PH_INT};

   localparam char_type CH_DOLLAR = 8'h24;
   localparam char_type CH_STAR   = 8'h2A;
   localparam char_type CH_COMMA  = 8'h2C;
   localparam char_type CH_DOT    = 8'h2E;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;
   localparam char_type CH_A      = 8'h41;
   localparam char_type CH_E      = 8'h45;
   localparam char_type CH_N      = 8'h4E;

   localparam logic [2:0] SYNC_LEN = 3'd7;

   localparam logic [3:0] TOK_STATUS   = 4'd1;
   localparam logic [3:0] TOK_LAT      = 4'd2;
   localparam logic [3:0] TOK_LAT_HEMI = 4'd3;
   localparam logic [3:0] TOK_LON      = 4'd4;
   localparam logic [3:0] TOK_LON_HEMI = 4'd5;
   localparam logic [3:0] TOK_LAST     = 4'd15;

   localparam logic [1:0] LEN_MAX = 2'd3;

   // Characters of the sentence prefix "$GPRMC," by position.
   function automatic char_type sync_char(input logic [2:0] pos);
      char_type c;
      case (pos)
         3'd0: c = CH_DOLLAR;
         3'd1: c = 8'h47;
         3'd2: c = 8'h50;
         3'd3: c = 8'h52;
         3'd4: c = 8'h4D;
         3'd5: c = 8'h43;
         3'd6: c = CH_COMMA;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
      logic [POW_W-1:0] p;
      case (n)
         3'd0: p = 24'd1;
         3'd1: p = 24'd10;
         3'd2: p = 24'd100;
         3'd3: p = 24'd1000;
         3'd4: p = 24'd10000;
         3'd5: p = 24'd100000;
         3'd6: p = 24'd1000000;
         3'd7: p = 24'd10000000;
         default: p = 24'd1;
      endcase
      return p;
   endfunction

endpackage

>>> rtl/nrmc_if.sv
// Valid/ready channel interfaces for received characters and position results.
`timescale 1ns / 1ps
interface nrmc_req_if;
   logic                  valid;
   logic                  ready;
   nrmc_pkg::char_type    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  fix_active;
   nrmc_pkg::coord_type   latitude;
   nrmc_pkg::coord_type   longitude;

   modport source (output valid, output fix_active, output latitude, output longitude,
                   input ready);
   modport sink   (input valid, input fix_active, input latitude, input longitude,
                   output ready);
endinterface

>>> rtl/nmea_rmc_position_parser_top.sv
// Top level of the RMC sentence position parser.
`timescale 1ns / 1ps
// Takes one ASCII character per transfer on req_chan, hunts for "$GPRMC,", splits the
// body at commas (empty fields skipped) and, at each '*', sends one result on rsp_chan:
// the fix flag and the held latitude and longitude, scaled by 10^FRAC_DIGITS and negative
// unless the hemisphere is N or E. Position values update only on an active fix. A
// character is taken every cycle unless stalled; it passes an input register and then one
// combinational step into the result register. Only a result waiting on rsp_chan without
// ready stalls the input.
module nmea_rmc_position_parser_top #(
   parameter int FRAC_DIGITS = 5,
   parameter int INT_DIGITS  = 5
) (
   input logic        clock,
   input logic        reset,
   nrmc_req_if.sink   req_chan,
   nrmc_rsp_if.source rsp_chan
);
   import nrmc_pkg::*;

   // Input stage
   char_type   byte_ff, byte_in;
   logic       byte_vld_ff, byte_vld_in;
   logic       advance, proc;

   // Parser state
   logic [2:0] sync_ff, sync_in;
   logic       in_body_ff, in_body_in;
   logic [3:0] field_ff, field_in;
   logic [1:0] len_ff, len_in;
   char_type   first_ff, first_in;
   num_type    num_ff, num_in;
   logic       status_ff, status_in;
   mag_type    lat_mag_ff, lat_mag_in;
   logic       lat_north_ff, lat_north_in;
   mag_type    lon_mag_ff, lon_mag_in;
   logic       lon_east_ff, lon_east_in;
   coord_type  held_lat_ff, held_lat_in;
   coord_type  held_lon_ff, held_lon_in;

   // Result stage
   logic       rsp_vld_ff, rsp_vld_in;
   logic       rsp_fix_ff, rsp_fix_in;
   coord_type  rsp_lat_ff, rsp_lat_in;
   coord_type  rsp_lon_ff, rsp_lon_in;

   num_type    feed_nxt;
   mag_type    scaled;
   logic       tok_end, single;
   logic       fin_status, fin_north, fin_east;
   mag_type    fin_lat, fin_lon;
   logic [3:0] fin_field;
   logic       sync_hit;
   logic [2:0] sync_next;
   coord_type  new_lat, new_lon;
   logic       emit;

   nrmc_numfeed #(
      .FRAC_DIGITS(FRAC_DIGITS),
      .INT_DIGITS (INT_DIGITS)
   ) u_numfeed (
      .cur    (num_ff),
      .rx_char(byte_ff),
      .nxt    (feed_nxt)
   );

   nrmc_scale #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_scale (
      .acc (num_ff.acc),
      .seen(num_ff.seen),
      .mag (scaled)
   );

   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign proc           = byte_vld_ff && advance;
   assign req_chan.ready = !byte_vld_ff || advance;

   assign byte_vld_in = (req_chan.valid && req_chan.ready) ? 1'b1 :
                        (proc ? 1'b0 : byte_vld_ff);
   assign byte_in     = (req_chan.valid && req_chan.ready) ? req_chan.rx_byte : byte_ff;

   // Values as they stand after closing the current token, if it is non-empty.
   assign tok_end = (len_ff != 2'd0);
   assign single  = (len_ff == 2'd1);

   always_comb begin
      fin_status = status_ff;
      fin_north  = lat_north_ff;
      fin_east   = lon_east_ff;
      fin_lat    = lat_mag_ff;
      fin_lon    = lon_mag_ff;
      if (tok_end) begin
         case (field_ff)
            TOK_STATUS:   fin_status = single && (first_ff == CH_A);
            TOK_LAT:      fin_lat    = scaled;
            TOK_LAT_HEMI: fin_north  = single && (first_ff == CH_N);
            TOK_LON:      fin_lon    = scaled;
            TOK_LON_HEMI: fin_east   = single && (first_ff == CH_E);
            default: begin
               fin_status = status_ff;
            end
         endcase
      end
   end

   assign fin_field = (field_ff != TOK_LAST) ? field_ff + 4'd1 : field_ff;
   assign new_lat   = fin_north ? {1'b0, fin_lat} : OUT_W'(0) - {1'b0, fin_lat};
   assign new_lon   = fin_east  ? {1'b0, fin_lon} : OUT_W'(0) - {1'b0, fin_lon};

   assign sync_hit  = (byte_ff == sync_char(sync_ff));
   assign sync_next = sync_hit ? sync_ff + 3'd1 : ((byte_ff == CH_DOLLAR) ? 3'd1 : 3'd0);

   always_comb begin
      sync_in      = sync_ff;
      in_body_in   = in_body_ff;
      field_in     = field_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      num_in       = num_ff;
      status_in    = status_ff;
      lat_mag_in   = lat_mag_ff;
      lat_north_in = lat_north_ff;
      lon_mag_in   = lon_mag_ff;
      lon_east_in  = lon_east_ff;
      held_lat_in  = held_lat_ff;
      held_lon_in  = held_lon_ff;
      emit         = 1'b0;
      if (proc) begin
         if (!in_body_ff) begin
            if (sync_next == SYNC_LEN) begin
               in_body_in   = 1'b1;
               sync_in      = 3'd0;
               field_in     = 4'd0;
               len_in       = 2'd0;
               first_in     = '0;
               num_in       = NUM_CLEAR;
               status_in    = 1'b0;
               lat_mag_in   = '0;
               lat_north_in = 1'b0;
               lon_mag_in   = '0;
               lon_east_in  = 1'b0;
            end else begin
               sync_in = sync_next;
            end
         end else if ((byte_ff == CH_COMMA) || (byte_ff == CH_STAR)) begin
            if (tok_end) begin
               status_in    = fin_status;
               lat_mag_in   = fin_lat;
               lat_north_in = fin_north;
               lon_mag_in   = fin_lon;
               lon_east_in  = fin_east;
               field_in     = fin_field;
               len_in       = 2'd0;
               first_in     = '0;
               num_in       = NUM_CLEAR;
            end
            if (byte_ff == CH_STAR) begin
               emit       = 1'b1;
               in_body_in = 1'b0;
               sync_in    = 3'd0;
               if (fin_status) begin
                  held_lat_in = new_lat;
                  held_lon_in = new_lon;
               end
            end
         end else begin
            if (len_ff == 2'd0) begin
               first_in = byte_ff;
            end
            if (len_ff != LEN_MAX) begin
               len_in = len_ff + 2'd1;
            end
            num_in = feed_nxt;
         end
      end
   end

   assign rsp_vld_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);
   assign rsp_fix_in = emit ? fin_status : rsp_fix_ff;
   assign rsp_lat_in = emit ? held_lat_in : rsp_lat_ff;
   assign rsp_lon_in = emit ? held_lon_in : rsp_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         sync_ff      <= 3'd0;
         in_body_ff   <= 1'b0;
         field_ff     <= 4'd0;
         len_ff       <= 2'd0;
         first_ff     <= '0;
         num_ff       <= NUM_CLEAR;
         status_ff    <= 1'b0;
         lat_mag_ff   <= '0;
         lat_north_ff <= 1'b0;
         lon_mag_ff   <= '0;
         lon_east_ff  <= 1'b0;
         held_lat_ff  <= '0;
         held_lon_ff  <= '0;
      end else begin
         byte_vld_ff  <= byte_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         sync_ff      <= sync_in;
         in_body_ff   <= in_body_in;
         field_ff     <= field_in;
         len_ff       <= len_in;
         first_ff     <= first_in;
         num_ff       <= num_in;
         status_ff    <= status_in;
         lat_mag_ff   <= lat_mag_in;
         lat_north_ff <= lat_north_in;
         lon_mag_ff   <= lon_mag_in;
         lon_east_ff  <= lon_east_in;
         held_lat_ff  <= held_lat_in;
         held_lon_ff  <= held_lon_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      rsp_fix_ff <= rsp_fix_in;
      rsp_lat_ff <= rsp_lat_in;
      rsp_lon_ff <= rsp_lon_in;
   end

   assign rsp_chan.valid      = rsp_vld_ff;
   assign rsp_chan.fix_active = rsp_fix_ff;
   assign rsp_chan.latitude   = rsp_lat_ff;
   assign rsp_chan.longitude  = rsp_lon_ff;

   // A terminator inside a body always produces a result in the next cycle.
   a_star_emits: assert property (@(posedge clock) disable iff (reset)
      proc && in_body_ff && (byte_ff == CH_STAR) |=> rsp_vld_ff)
      else $error("terminator did not produce a result");

   // Without an active fix the held position must not move.
   a_inactive_holds: assert property (@(posedge clock) disable iff (reset)
      proc && in_body_ff && (byte_ff == CH_STAR) && !fin_status
      |=> $stable(held_lat_ff) && $stable(held_lon_ff))
      else $error("held position changed without an active fix");

   // The prefix hunt never rests on a completed prefix.
   a_sync_range: assert property (@(posedge clock) disable iff (reset)
      !in_body_ff |-> (sync_ff != SYNC_LEN))
      else $error("prefix position out of range");

   // Fraction digit count stays within the configured precision.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      num_ff.seen <= 3'(FRAC_DIGITS))
      else $error("fraction digit count exceeds precision");

   // No fraction digits are counted before the decimal point.
   a_int_no_frac: assert property (@(posedge clock) disable iff (reset)
      (num_ff.phase == PH_INT) |-> (num_ff.seen == 3'd0))
      else $error("fraction digits counted in integer part");

endmodule

>>> rtl/nrmc_numfeed.sv
// Decimal number accumulation for one character of a coordinate token.
`timescale 1ns / 1ps
module nrmc_numfeed #(
   parameter int FRAC_DIGITS = 5,
   parameter int INT_DIGITS  = 5
) (
   input  nrmc_pkg::num_type  cur,
   input  nrmc_pkg::char_type rx_char,
   output nrmc_pkg::num_type  nxt
);
   import nrmc_pkg::*;

   localparam mag_type IntMax      = ACC_W'(10**INT_DIGITS - 1);
   localparam mag_type IntMaxDiv10 = ACC_W'((10**INT_DIGITS - 1) / 10);

   logic               is_digit;
   logic [3:0]         digit;
   logic [ACC_W+3:0]   times10;

   assign is_digit = (rx_char >= CH_ZERO) && (rx_char <= CH_NINE);
   assign digit    = 4'(rx_char - CH_ZERO);
   assign times10  = ({4'b0, cur.acc} << 3) + ({4'b0, cur.acc} << 1)
                     + (ACC_W+4)'(digit);

   always_comb begin
      nxt = cur;
      case (cur.phase)
         PH_INT: begin
            if (is_digit) begin
               if ((cur.acc > IntMaxDiv10) || (times10 > {4'b0, IntMax})) begin
                  nxt.acc = IntMax;
               end else begin
                  nxt.acc = times10[ACC_W-1:0];
               end
            end else if (rx_char == CH_DOT) begin
               nxt.phase = PH_FRAC;
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               // Digits past the fraction precision are dropped.
               if (cur.seen < 3'(FRAC_DIGITS)) begin
                  nxt.acc  = times10[ACC_W-1:0];
                  nxt.seen = cur.seen + 3'd1;
               end
            end else begin
               nxt.phase = PH_STOP;
            end
         end
         PH_STOP: begin
            nxt = cur;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

>>> rtl/nrmc_scale.sv
// Scales an accumulated coordinate to the full fraction precision.
`timescale 1ns / 1ps
module nrmc_scale #(
   parameter int FRAC_DIGITS = 5
) (
   input  nrmc_pkg::mag_type acc,
   input  logic [2:0]        seen,
   output nrmc_pkg::mag_type mag
);
   import nrmc_pkg::*;

   logic [2:0]             missing;
   logic [ACC_W+POW_W-1:0] product;

   assign missing = 3'(FRAC_DIGITS) - seen;
   assign product = {{POW_W{1'b0}}, acc} * {{ACC_W{1'b0}}, pow10(missing)};
   assign mag     = product[ACC_W-1:0];

endmodule

>>> sim/nmea_rmc_position_parser_top_tb.sv
// Self-checking testbench for the RMC position parser: directed sentences, random traffic.
`timescale 1ns / 1ps
module nmea_rmc_position_parser_top_tb;
   import nrmc_pkg::*;

   localparam int FRAC_DIGITS = 5;
   localparam int INT_DIGITS  = 5;

   typedef struct packed {
      logic      fix;
      coord_type lat;
      coord_type lon;
   } fix_report_type;

   logic clock = 1'b0;
   logic reset;

   nrmc_req_if req_chan();
   nrmc_rsp_if rsp_chan();

   nmea_rmc_position_parser_top #(
      .FRAC_DIGITS(FRAC_DIGITS),
      .INT_DIGITS (INT_DIGITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   int idle_pct  = 0;
   int stall_pct = 0;
   int error_count = 0;
   int body_chars = 0;
   int reports_made = 0;

   fix_report_type expected_reports[$];
   char_type       line_buf[$];

   // Sentence tracker state.
   string     rmc_prefix = "$GPRMC,";
   logic [2:0] trk_sync;
   bit         trk_body;
   logic [3:0] trk_token;
   logic [1:0] trk_len;
   char_type   trk_first;
   mag_type    trk_acc;
   logic [2:0] trk_seen;
   phase_type  trk_phase;
   bit         trk_active;
   mag_type    trk_lat_mag;
   mag_type    trk_lon_mag;
   bit         trk_north;
   bit         trk_east;
   coord_type  trk_held_lat;
   coord_type  trk_held_lon;

   function automatic longint unsigned ten_pow(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   task automatic clear_token_state();
      trk_len   = '0;
      trk_first = '0;
      trk_acc   = '0;
      trk_seen  = '0;
      trk_phase = PH_INT;
   endtask

   task automatic open_body();
      trk_body    = 1'b1;
      trk_sync    = '0;
      trk_token   = '0;
      clear_token_state();
      trk_active  = 1'b0;
      trk_lat_mag = '0;
      trk_north   = 1'b0;
      trk_lon_mag = '0;
      trk_east    = 1'b0;
   endtask

   task automatic accumulate_digit(input char_type c);
      longint unsigned int_max;
      longint unsigned acc;
      longint unsigned d;
      int_max = ten_pow(INT_DIGITS) - 1;
      acc = trk_acc;
      if (trk_phase == PH_STOP) return;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         if (trk_phase == PH_INT) begin
            if (acc > int_max / 10 || acc * 10 + d > int_max) acc = int_max;
            else acc = acc * 10 + d;
         end else if (trk_seen < FRAC_DIGITS) begin
            acc = acc * 10 + d;
            trk_seen = trk_seen + 1'b1;
         end
         trk_acc = mag_type'(acc);
      end else if (c == CH_DOT && trk_phase == PH_INT) begin
         trk_phase = PH_FRAC;
      end else begin
         trk_phase = PH_STOP;
      end
   endtask

   function automatic mag_type scaled_magnitude();
      logic [2:0] missing;
      longint unsigned acc;
      missing = 3'(FRAC_DIGITS - trk_seen);
      acc = trk_acc;
      return mag_type'(acc * ten_pow(missing));
   endfunction

   task automatic close_token();
      bit single;
      single = (trk_len == 2'd1);
      case (trk_token)
         TOK_STATUS:   trk_active  = single && trk_first == CH_A;
         TOK_LAT:      trk_lat_mag = scaled_magnitude();
         TOK_LAT_HEMI: trk_north   = single && trk_first == CH_N;
         TOK_LON:      trk_lon_mag = scaled_magnitude();
         TOK_LON_HEMI: trk_east    = single && trk_first == CH_E;
         default: ;
      endcase
      if (trk_token != TOK_LAST) trk_token = trk_token + 1'b1;
      clear_token_state();
   endtask

   // Advances the tracker by one transferred character; a '*' in a body yields a report.
   task automatic track_char(input char_type c);
      fix_report_type rep;
      if (!trk_body) begin
         if (c == char_type'(rmc_prefix[trk_sync])) trk_sync = trk_sync + 1'b1;
         else trk_sync = (c == CH_DOLLAR) ? 3'd1 : 3'd0;
         if (trk_sync == SYNC_LEN) open_body();
         return;
      end
      body_chars++;
      if (c == CH_COMMA) begin
         if (trk_len != 0) close_token();
      end else if (c == CH_STAR) begin
         if (trk_len != 0) close_token();
         if (trk_active) begin
            trk_held_lat = trk_north ? coord_type'({1'b0, trk_lat_mag})
                                     : coord_type'(35'd0 - {1'b0, trk_lat_mag});
            trk_held_lon = trk_east ? coord_type'({1'b0, trk_lon_mag})
                                    : coord_type'(35'd0 - {1'b0, trk_lon_mag});
         end
         rep.fix = trk_active;
         rep.lat = trk_held_lat;
         rep.lon = trk_held_lon;
         expected_reports.push_back(rep);
         reports_made++;
         trk_body = 1'b0;
         trk_sync = '0;
      end else begin
         if (trk_len == 0) trk_first = c;
         if (trk_len != LEN_MAX) trk_len = trk_len + 1'b1;
         accumulate_digit(c);
      end
   endtask

   task automatic send_char(input char_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      track_char(c);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(char_type'(s[i]));
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
      line_buf.delete();
   endtask

   // Holds the sender off until every pending report has been transferred.
   task automatic wait_for_reports();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input fix_report_type want,
                                input fix_report_type got);
      if (error_count < 10)
         $display("%0t: %s: expected fix %0d lat %0d lon %0d, got fix %0d lat %0d lon %0d",
                  $realtime, what, want.fix, want.lat, want.lon, got.fix, got.lat, got.lon);
      error_count++;
   endtask

   always @(posedge clock) begin
      fix_report_type want;
      fix_report_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.fix = rsp_chan.fix_active;
         got.lat = rsp_chan.latitude;
         got.lon = rsp_chan.longitude;
         if (expected_reports.size() == 0) begin
            flag_mismatch("unexpected result", '0, got);
         end else begin
            want = expected_reports.pop_front();
            if (got.fix !== want.fix || got.lat !== want.lat || got.lon !== want.lon)
               flag_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   // Random sentence pieces.
   task automatic add_separator();
      line_buf.push_back(CH_COMMA);
      if ($urandom_range(7) == 0) line_buf.push_back(CH_COMMA);
   endtask

   task automatic add_digits(input int n, input bit all_nines);
      for (int i = 0; i < n; i++)
         line_buf.push_back(all_nines ? CH_NINE : char_type'(CH_ZERO + $urandom_range(9)));
   endtask

   task automatic add_number(input int max_int);
      int  n_int;
      int  n_frac;
      bit  nines;
      string junk;
      junk = "-+ .x";
      nines = ($urandom_range(5) == 0);
      n_int = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, max_int);
      add_digits(n_int, nines);
      if ($urandom_range(4) != 0) begin
         line_buf.push_back(CH_DOT);
         n_frac = ($urandom_range(7) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
         add_digits(n_frac, nines);
      end
      if ($urandom_range(11) == 0) begin
         if ($urandom_range(3) == 0) line_buf.push_back(char_type'($urandom_range(255)));
         else line_buf.push_back(char_type'(junk[$urandom_range(4)]));
         add_digits($urandom_range(2), 1'b0);
      end
   endtask

   task automatic add_hemisphere(input char_type want, input char_type other);
      case ($urandom_range(8))
         0, 1, 2, 3, 4: line_buf.push_back(want);
         5: line_buf.push_back(other);
         6: ;
         7: begin
            line_buf.push_back(want);
            line_buf.push_back(want);
         end
         default: line_buf.push_back(char_type'($urandom_range(8'h41, 8'h7A)));
      endcase
   endtask

   task automatic add_body();
      string hex;
      hex = "0123456789ABCDEF";
      add_digits($urandom_range(10), 1'b0);
      add_separator();
      case ($urandom_range(7))
         0, 1, 2, 3: line_buf.push_back(CH_A);
         4: put_text("V");
         5: ;
         6: put_text("AA");
         default: line_buf.push_back(char_type'($urandom_range(255)));
      endcase
      add_separator();
      add_number(4);
      add_separator();
      add_hemisphere(CH_N, 8'h53);
      add_separator();
      add_number(5);
      add_separator();
      add_hemisphere(CH_E, 8'h57);
      repeat ($urandom_range(14)) begin
         add_separator();
         if ($urandom_range(9) == 0) line_buf.push_back(char_type'($urandom_range(255)));
         else add_digits($urandom_range(1, 4), 1'b0);
      end
      if ($urandom_range(9) != 0) begin
         line_buf.push_back(CH_STAR);
         line_buf.push_back(char_type'(hex[$urandom_range(15)]));
         line_buf.push_back(char_type'(hex[$urandom_range(15)]));
         put_text("\r\n");
      end
   endtask

   task automatic build_random_line();
      case ($urandom_range(9))
         0: repeat ($urandom_range(1, 24)) line_buf.push_back(char_type'($urandom_range(255)));
         1: begin
            put_text(rmc_prefix.substr(0, $urandom_range(5)));
            line_buf.push_back(char_type'($urandom_range(255)));
         end
         default: begin
            put_text(rmc_prefix);
            add_body();
         end
      endcase
   endtask

   // Directed tests.
   task automatic test_prefix_hunt();
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);
      put_text("*$$GPRMC,1,A,0000.00000,N,00000.00000,E*00\r\n");
      put_text("$GP$GPRMC,2,A,4807.038,N,01131.000,E,022.4*6A\r\n");
      put_text("$GPRMD,$GPRMC,3,A,1.5,S,2.25,W*00\r\n");
      send_line();
   endtask

   task automatic test_fix_status();
      put_text("$GPRMC,4,V,1234.5,N,1.0,E*00\r\n");
      put_text("$GPRMC,,A*00\r\n");
      put_text("$GPRMC,5,AA,1,N,1,E*00\r\n");
      put_text("$GPRMC,6,A,7,NN,8,*00\r\n");
      put_text("$GPRMC,7,A*00\r\n");
      send_line();
   endtask

   task automatic test_number_syntax();
      put_text("$GPRMC,8,A,-12.5,N,12.3.4,E*00\r\n");
      put_text("$GPRMC,9,A,12 3,N,1x2,E*00\r\n");
      put_text("$GPRMC,1,A,99999.99999,N,99999.99999,E*00\r\n");
      put_text("$GPRMC,1,A,999999999.999999999,S,123456.12345678,W*00\r\n");
      put_text("$GPRMC,1,A,.5,N,00042.,E*00\r\n");
      send_line();
   endtask

   task automatic test_long_sentence();
      put_text("$GPRMC,1,A,12.5,N,3.75,E,a,b,c,d,e,f,g,h,i,j,k,$,m,N*00\r\n");
      put_text("$GPRMC,1,A,1,N,2,E\r\n$GPRMC,1,A,3,N*00\r\n");
      send_line();
   endtask

   task automatic test_random_traffic(input int idle, input int stall);
      int body_start;
      int reports_start;
      int lines;
      idle_pct = idle;
      stall_pct = stall;
      body_start = body_chars;
      reports_start = reports_made;
      lines = 0;
      while (body_chars - body_start < 280 || reports_made - reports_start < 5) begin
         build_random_line();
         send_line();
         lines++;
         if (lines % 9 == 4) wait_for_reports();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      trk_held_lat = '0;
      trk_held_lon = '0;
      open_body();
      trk_body = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_prefix_hunt();
      test_fix_status();
      test_number_syntax();
      test_long_sentence();
      wait_for_reports();
      test_random_traffic(0, 0);
      test_random_traffic(75, 0);
      test_random_traffic(0, 75);
      test_random_traffic(20, 20);

      wait_for_reports();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("nmea_rmc_position_parser_top_tb: clean");
      else
         $display("nmea_rmc_position_parser_top_tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("nmea_rmc_position_parser_top_tb: errors");
      $finish;
   end

endmodule

>>> nmea_rmc_position_parser_top.f
rtl/nrmc_pkg.sv
rtl/nrmc_if.sv
rtl/nrmc_numfeed.sv
rtl/nrmc_scale.sv
rtl/nmea_rmc_position_parser_top.sv
sim/nmea_rmc_position_parser_top_tb.sv
